### hdl/periodic_task_ready_table_top_assert.svh
// Assertion macros for the periodic task ready table.
`ifndef PERIODIC_TASK_READY_TABLE_TOP_ASSERT_SVH
`define PERIODIC_TASK_READY_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define PTRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptrt: same-cycle check failed");
`define PTRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptrt: next-cycle check failed");
`else
`define PTRT_ASSERT_IMP(lbl, ante, cons)
`define PTRT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/ptrt_pkg.sv
// Shared types and constants of the periodic task ready table.
package ptrt_pkg;

  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 16;
  localparam int TASK_W   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_START    = 3'd2,
    KIND_STOP     = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_DISPATCH = 3'd5
  } kind_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

### hdl/periodic_task_ready_table_top.sv
// Periodic task ready table: slot table with a one-slot-per-cycle sequencer that waits on a held result.
//
// Holds MAX_TASKS task slots (numbered from 1), each with valid and ready flags, a
// 16-bit period and a saturating tick count. One command word is taken in the
// cycle the block is idle, and the sequencer then works through it one step per
// cycle on the single read/update port of the slot table, unless a step that gives
// a result word must wait for the downstream side: delete, start, stop and unknown
// kinds take one step, tick visits every slot in turn (MAX_TASKS steps), dispatch
// walks up to the highest ready slot, or over every slot when none is ready (1 to
// MAX_TASKS steps), and create walks up to the lowest free slot, or over every
// slot when none is free (1 to MAX_TASKS steps). Results leave through an output
// register, so the next command word is taken while the last result still waits.
// Dispatch sends one word per ready slot, in ascending slot order, with tlast on
// the final one, or one word with tlast when none is ready; every other command
// gives one word with tlast set.
module periodic_task_ready_table_top #(
  parameter int MAX_TASKS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] slot, [19:4] period, [23:20] zero
  input  logic [23:0]                     s_axis_tdata,
  // [2:0] kind
  input  logic [ptrt_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] status, [4:1] task_res, [7:5] zero
  output logic [7:0]                      m_axis_tdata,
  // [0] fired
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import ptrt_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [5:0] MAX_SLOT = 6'(MAX_TASKS);

  state_e state_q, state_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [MAX_TASKS-1:0] used_q, used_d;
  logic [MAX_TASKS-1:0] ready_q, ready_d;

  logic              ov_q, ov_d;
  logic              status_q, status_d;
  logic [TASK_W-1:0] task_q, task_d;
  logic              fired_q, fired_d;
  logic              last_q, last_d;

  logic [PERIOD_W-1:0]   period_mem [MAX_TASKS];
  logic [COUNT_BITS-1:0] count_mem [MAX_TASKS];

  logic                  period_we;
  logic                  count_we;
  logic [IDX_W-1:0]      count_waddr;
  logic [COUNT_BITS-1:0] count_wdata;

  logic [PERIOD_W-1:0]   rd_period;
  logic [COUNT_BITS-1:0] rd_count;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  reach;

  logic                  can_emit;
  logic                  need_emit;
  logic                  step_en;
  logic                  is_last;
  logic                  hit;
  logic                  more;
  logic [MAX_TASKS-1:0]  above;
  logic [5:0]            slot6;
  logic [5:0]            slot_m1;
  logic [IDX_W-1:0]      sidx;
  logic                  in_range;
  logic                  slot_ok;
  logic [5:0]            num6;

  assign rd_period = period_mem[idx_q];
  assign rd_count  = count_mem[idx_q];
  assign cnt_inc   = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
  assign reach     = CMP_W'(cnt_inc) >= CMP_W'(rd_period);

  assign can_emit = !ov_q || m_axis_tready;
  assign is_last  = (idx_q == LAST_IDX);
  assign hit      = used_q[idx_q] && ready_q[idx_q];
  // Any ready slot above the current one decides tlast on dispatch.
  assign above    = ((used_q & ready_q) >> idx_q) >> 1;
  assign more     = |above;
  assign num6     = 6'(idx_q) + 6'd1;

  assign slot6    = {2'b00, slot_q};
  assign slot_m1  = slot6 - 6'd1;
  assign sidx     = slot_m1[IDX_W-1:0];
  assign in_range = (slot6 != 6'd0) && (slot6 <= MAX_SLOT);
  assign slot_ok  = in_range && used_q[sidx];

  always_comb begin
    unique case (kind_q)
      KIND_CREATE:   need_emit = !used_q[idx_q] || is_last;
      KIND_TICK:     need_emit = is_last;
      KIND_DISPATCH: need_emit = hit || is_last;
      default:       need_emit = 1'b1;
    endcase
  end

  assign step_en = (state_q == ST_SCAN) && (!need_emit || can_emit);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    slot_d      = slot_q;
    period_d    = period_q;
    idx_d       = idx_q;
    used_d      = used_q;
    ready_d     = ready_q;
    ov_d        = ov_q && !m_axis_tready;
    status_d    = status_q;
    task_d      = task_q;
    fired_d     = fired_q;
    last_d      = last_q;
    period_we   = 1'b0;
    count_we    = 1'b0;
    count_waddr = idx_q;
    count_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d   = s_axis_tuser;
          slot_d   = s_axis_tdata[3:0];
          period_d = s_axis_tdata[19:4];
          idx_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step_en) begin
          unique case (kind_q)
            KIND_CREATE: begin
              if (!used_q[idx_q]) begin
                used_d[idx_q]  = 1'b1;
                ready_d[idx_q] = 1'b0;
                period_we      = 1'b1;
                count_we       = 1'b1;
                ov_d     = 1'b1;
                status_d = STATUS_OK;
                task_d   = num6[TASK_W-1:0];
                fired_d  = 1'b0;
                last_d   = 1'b1;
                state_d  = ST_IDLE;
              end else if (is_last) begin
                ov_d     = 1'b1;
                status_d = STATUS_ERR;
                task_d   = '0;
                fired_d  = 1'b0;
                last_d   = 1'b1;
                state_d  = ST_IDLE;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
            KIND_DELETE, KIND_START, KIND_STOP: begin
              ov_d     = 1'b1;
              task_d   = '0;
              fired_d  = 1'b0;
              last_d   = 1'b1;
              state_d  = ST_IDLE;
              status_d = slot_ok ? STATUS_OK : STATUS_ERR;
              if (slot_ok) begin
                if (kind_q == KIND_DELETE) begin
                  used_d[sidx]  = 1'b0;
                  ready_d[sidx] = 1'b0;
                end else if (kind_q == KIND_START) begin
                  ready_d[sidx] = 1'b1;
                  count_we      = 1'b1;
                  count_waddr   = sidx;
                end else begin
                  ready_d[sidx] = 1'b0;
                end
              end
            end
            KIND_TICK: begin
              if (used_q[idx_q] && !ready_q[idx_q]) begin
                count_we = 1'b1;
                if (reach) begin
                  ready_d[idx_q] = 1'b1;
                end else begin
                  count_wdata = cnt_inc;
                end
              end
              if (is_last) begin
                ov_d     = 1'b1;
                status_d = STATUS_OK;
                task_d   = '0;
                fired_d  = 1'b0;
                last_d   = 1'b1;
                state_d  = ST_IDLE;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
            KIND_DISPATCH: begin
              if (hit) begin
                ov_d     = 1'b1;
                status_d = STATUS_OK;
                task_d   = num6[TASK_W-1:0];
                fired_d  = 1'b1;
                last_d   = !more;
                // Period zero keeps the slot ready for every dispatch.
                if (rd_period != '0) begin
                  ready_d[idx_q] = 1'b0;
                end
              end else if (is_last) begin
                ov_d     = 1'b1;
                status_d = STATUS_OK;
                task_d   = '0;
                fired_d  = 1'b0;
                last_d   = 1'b1;
              end
              if ((hit && !more) || is_last) begin
                state_d = ST_IDLE;
              end else begin
                idx_d = idx_q + IDX_W'(1);
              end
            end
            default: begin
              ov_d     = 1'b1;
              status_d = STATUS_ERR;
              task_d   = '0;
              fired_d  = 1'b0;
              last_d   = 1'b1;
              state_d  = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
      ready_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      ready_q <= ready_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    slot_q   <= slot_d;
    period_q <= period_d;
    status_q <= status_d;
    task_q   <= task_d;
    fired_q  <= fired_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (period_we) begin
      period_mem[idx_q] <= period_q;
    end
    if (count_we) begin
      count_mem[count_waddr] <= count_wdata;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, task_q, status_q};
  assign m_axis_tuser  = fired_q;
  assign m_axis_tlast  = last_q;

  `include "periodic_task_ready_table_top_assert.svh"

  `PTRT_ASSERT_NXT(a_accept_starts_scan, s_axis_tvalid && s_axis_tready, state_q == ST_SCAN)
  `PTRT_ASSERT_IMP(a_idx_in_range, state_q == ST_SCAN, idx_q <= LAST_IDX)
  `PTRT_ASSERT_IMP(a_ready_only_used, 1'b1, (ready_q & ~used_q) == '0)
  `PTRT_ASSERT_NXT(a_dispatch_fires, step_en && kind_q == KIND_DISPATCH && hit, m_axis_tvalid && m_axis_tuser)

endmodule
